// ===== rtl/mrcs_pkg.sv =====
// shared constants of the matrix row/column statistics unit
`timescale 1ns / 1ps
`default_nettype none

package mrcs_pkg;

  // default sizes
  localparam int MAX_DIM_DEF      = 8;
  localparam int ELEMENT_BITS_DEF = 16;

  // fixed field widths
  localparam int CFG_W   = 4;
  localparam int CIDX_W  = 2;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 19;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CIDX_W-1:0] REG_COL_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_MODE      = 2'd2;

  // register reset values
  localparam logic [CFG_W-1:0] ROW_COUNT_RST = 4'd8;
  localparam logic [CFG_W-1:0] COL_COUNT_RST = 4'd8;

  // mode codes
  localparam logic [CFG_W-1:0] MODE_DIAG     = 4'd0;
  localparam logic [CFG_W-1:0] MODE_ANTIDIAG = 4'd1;
  localparam logic [CFG_W-1:0] MODE_ROW_SUM  = 4'd2;
  localparam logic [CFG_W-1:0] MODE_COL_SUM  = 4'd3;
  localparam logic [CFG_W-1:0] MODE_ROW_MAX  = 4'd4;
  localparam logic [CFG_W-1:0] MODE_COL_MAX  = 4'd5;
  localparam logic [CFG_W-1:0] MODE_ROW_MIN  = 4'd6;
  localparam logic [CFG_W-1:0] MODE_COL_MIN  = 4'd7;
  localparam logic [CFG_W-1:0] MODE_ROW_AVG  = 4'd8;
  localparam logic [CFG_W-1:0] MODE_COL_AVG  = 4'd9;
  localparam logic [CFG_W-1:0] MODE_UPPER    = 4'd10;
  localparam logic [CFG_W-1:0] MODE_LOWER    = 4'd11;

  localparam logic [CFG_W-1:0] MODE_RST = MODE_ROW_SUM;

  // input action codes
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_COMPUTE = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/mrcs_ram.sv =====
// generic one-write one-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module mrcs_ram #(
  parameter int WIDTH = mrcs_pkg::ELEMENT_BITS_DEF,
  parameter int DEPTH = mrcs_pkg::MAX_DIM_DEF * mrcs_pkg::MAX_DIM_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/mrcs_div.sv =====
// bit-serial signed by unsigned divider, quotient truncated toward zero
`timescale 1ns / 1ps
`default_nettype none

module mrcs_div #(
  parameter int AW = 20,
  parameter int DW = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [AW-1:0] dividend_i,
  input  wire logic        [DW-1:0] divisor_i,
  output logic                      done_o,
  output logic signed      [AW-1:0] quotient_o
);

  localparam int CNT_W = $clog2(AW + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AW-1:0]    mag_q;
  logic [DW-1:0]    rem_q;
  logic [DW-1:0]    dsr_q;
  logic             neg_q;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem_q, mag_q[AW-1]};
  assign fits  = (trial >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(AW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= dividend_i[AW-1] ? (~dividend_i + AW'(1)) : dividend_i;
      neg_q <= dividend_i[AW-1];
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      // one restoring step per cycle, quotient bits shift in from the bottom
      rem_q <= fits ? DW'(trial - {1'b0, dsr_q}) : DW'(trial);
      mag_q <= {mag_q[AW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? signed'(~mag_q + AW'(1)) : signed'(mag_q);

endmodule

`default_nettype wire

// ===== rtl/matrix_row_column_statistics_unit.sv =====
// top level of the matrix row/column statistics unit
//
// channel  direction  handshake              payload
// in       sink       in_valid_i/in_stall_o   action_i, element_i
// out      source     out_valid_o/out_stall_i position_o, result_value_o, not_square_o, last_o
// cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a load writes the element to the matrix ram at once; a compute walks the ram one
// read at a time (read, then use): a masked element is read, used and emitted; a
// row or column sum/max/min reads each element in turn, then emits; an average adds
// a divide step; input is stalled until the last result sits in the output register;
// output stalls hold the walk in its emit step; the ram is not cleared at reset

`timescale 1ns / 1ps
`default_nettype none

module matrix_row_column_statistics_unit #(
  parameter int MAX_DIM      = mrcs_pkg::MAX_DIM_DEF,
  parameter int ELEMENT_BITS = mrcs_pkg::ELEMENT_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic                                action_i,
  input  wire logic signed [ELEMENT_BITS-1:0]      element_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic        [mrcs_pkg::POS_W-1:0]        position_o,
  output logic signed [mrcs_pkg::VALUE_W-1:0]      result_value_o,
  output logic                                     not_square_o,
  output logic                                     last_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic   [mrcs_pkg::CIDX_W-1:0]       cfg_index_i,
  input  wire logic   [mrcs_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ACC_W   = ELEMENT_BITS + IDX_W + 1;
  localparam int PROD_W  = IDX_W + DIM_W + 1;
  localparam int TOT_W   = 2 * DIM_W;
  localparam int VW      = mrcs_pkg::VALUE_W;
  localparam int EXT_W   = (ACC_W > VW) ? ACC_W : VW;
  localparam int CFG_W   = mrcs_pkg::CFG_W;

  localparam logic signed [EXT_W-1:0] VMAX =
    {{(EXT_W - VW + 1){1'b0}}, {(VW - 1){1'b1}}};
  localparam logic signed [EXT_W-1:0] VMIN =
    {{(EXT_W - VW + 1){1'b1}}, {(VW - 1){1'b0}}};

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_ACC  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  // configuration registers
  logic [CFG_W-1:0] row_q, col_q, mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= mrcs_pkg::ROW_COUNT_RST;
      col_q  <= mrcs_pkg::COL_COUNT_RST;
      mode_q <= mrcs_pkg::MODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        mrcs_pkg::REG_ROW_COUNT: row_q  <= cfg_data_i;
        mrcs_pkg::REG_COL_COUNT: col_q  <= cfg_data_i;
        mrcs_pkg::REG_MODE:      mode_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // clamped dimensions
  logic [DIM_W-1:0] rows, cols;

  always_comb begin
    if (row_q == '0) begin
      rows = DIM_W'(1);
    end else if (32'(row_q) > MAX_DIM) begin
      rows = DIM_W'(MAX_DIM);
    end else begin
      rows = DIM_W'(row_q);
    end
    if (col_q == '0) begin
      cols = DIM_W'(1);
    end else if (32'(col_q) > MAX_DIM) begin
      cols = DIM_W'(MAX_DIM);
    end else begin
      cols = DIM_W'(col_q);
    end
  end

  // mode decode
  logic mode_red, mode_mask, mode_diag, by_col;
  logic is_max, is_min, is_avg;

  assign mode_red  = (mode_q >= mrcs_pkg::MODE_ROW_SUM) && (mode_q <= mrcs_pkg::MODE_COL_AVG);
  assign mode_diag = (mode_q == mrcs_pkg::MODE_DIAG) || (mode_q == mrcs_pkg::MODE_ANTIDIAG);
  assign mode_mask = mode_diag || (mode_q == mrcs_pkg::MODE_UPPER)
                     || (mode_q == mrcs_pkg::MODE_LOWER);
  assign by_col    = mode_red && mode_q[0];
  assign is_max    = (mode_q == mrcs_pkg::MODE_ROW_MAX) || (mode_q == mrcs_pkg::MODE_COL_MAX);
  assign is_min    = (mode_q == mrcs_pkg::MODE_ROW_MIN) || (mode_q == mrcs_pkg::MODE_COL_MIN);
  assign is_avg    = (mode_q == mrcs_pkg::MODE_ROW_AVG) || (mode_q == mrcs_pkg::MODE_COL_AVG);

  // walk state
  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        i_q, i_d, j_q, j_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic                    ns_q, ns_d;
  logic [ADDR_W-1:0]       lp_q, lp_d;

  logic [DIM_W-1:0]  outer, inner;
  logic [IDX_W-1:0]  r_idx, c_idx;
  logic              i_last, j_last;
  logic [PROD_W-1:0] elem_idx;

  assign outer  = by_col ? cols : rows;
  assign inner  = by_col ? rows : cols;
  assign r_idx  = by_col ? j_q : i_q;
  assign c_idx  = by_col ? i_q : j_q;
  assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == outer;
  assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == inner;
  assign elem_idx = PROD_W'(r_idx) * PROD_W'(cols) + PROD_W'(c_idx);

  // load pointer and ram write side
  logic              in_acc, do_load, do_comp;
  logic [TOT_W-1:0]  total, wr_next;
  logic [ADDR_W-1:0] wr_addr;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign do_load    = in_acc && (action_i == mrcs_pkg::ACT_LOAD);
  assign do_comp    = in_acc && (action_i == mrcs_pkg::ACT_COMPUTE);

  assign total   = TOT_W'(rows) * TOT_W'(cols);
  assign wr_addr = (TOT_W'(lp_q) >= total) ? '0 : lp_q;
  assign wr_next = TOT_W'(wr_addr) + TOT_W'(1);

  always_comb begin
    lp_d = lp_q;
    if (do_load) begin
      lp_d = (wr_next >= total) ? '0 : wr_next[ADDR_W-1:0];
    end
  end

  logic [ELEMENT_BITS-1:0] rd_data;

  mrcs_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_load),
    .waddr_i (wr_addr),
    .wdata_i (element_i),
    .raddr_i (elem_idx[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  // average divider
  logic                    div_start, div_done;
  logic signed [ACC_W-1:0] div_quot;

  mrcs_div #(
    .AW (ACC_W),
    .DW (DIM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_d),
    .divisor_i  (inner),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // walk control
  logic signed [ACC_W-1:0] elem_v;
  logic                    keep;
  logic                    out_free;
  logic                    res_last;
  logic [DIM_W:0]          anti_sum;

  assign elem_v   = ACC_W'($signed(rd_data));
  assign anti_sum = (DIM_W + 1)'(i_q) + (DIM_W + 1)'(j_q) + (DIM_W + 1)'(1);
  assign out_free = !out_valid_o || !out_stall_i;
  assign res_last = ns_q || (i_last && (mode_red || j_last));

  always_comb begin
    unique case (mode_q)
      mrcs_pkg::MODE_DIAG:     keep = (i_q == j_q);
      mrcs_pkg::MODE_ANTIDIAG: keep = (anti_sum == (DIM_W + 1)'(cols));
      mrcs_pkg::MODE_UPPER:    keep = (i_q < j_q);
      mrcs_pkg::MODE_LOWER:    keep = (i_q > j_q);
      default:                 keep = 1'b0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    acc_d     = acc_q;
    ns_d      = ns_q;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (do_comp) begin
          i_d  = '0;
          j_d  = '0;
          ns_d = 1'b0;
          if (mode_diag && (rows != cols)) begin
            acc_d   = '0;
            ns_d    = 1'b1;
            state_d = ST_EMIT;
          end else if (mode_red || mode_mask) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (mode_mask) begin
          acc_d   = keep ? elem_v : '0;
          state_d = ST_EMIT;
        end else begin
          // the first element seeds every reduction
          if (j_q == '0) begin
            acc_d = elem_v;
          end else if (is_max) begin
            acc_d = (elem_v > acc_q) ? elem_v : acc_q;
          end else if (is_min) begin
            acc_d = (elem_v < acc_q) ? elem_v : acc_q;
          end else begin
            acc_d = acc_q + elem_v;
          end
          if (!j_last) begin
            j_d     = j_q + IDX_W'(1);
            state_d = ST_READ;
          end else if (is_avg) begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          acc_d   = div_quot;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          if (res_last) begin
            state_d = ST_IDLE;
          end else if (mode_mask && !j_last) begin
            j_d     = j_q + IDX_W'(1);
            state_d = ST_READ;
          end else begin
            i_d     = i_q + IDX_W'(1);
            j_d     = '0;
            state_d = ST_READ;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lp_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      ns_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      lp_q    <= lp_d;
      i_q     <= i_d;
      j_q     <= j_d;
      ns_q    <= ns_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // output register
  logic                    load_out;
  logic signed [EXT_W-1:0] acc_ext;
  logic signed [VW-1:0]    sat_v;
  logic                    out_valid_q;
  logic [mrcs_pkg::POS_W-1:0] pos_q;
  logic signed [VW-1:0]    val_q;
  logic                    ns_out_q, last_q;

  assign load_out = (state_q == ST_EMIT) && out_free;
  assign acc_ext  = EXT_W'(acc_q);

  always_comb begin
    if (acc_ext > VMAX) begin
      sat_v = VW'(VMAX);
    end else if (acc_ext < VMIN) begin
      sat_v = VW'(VMIN);
    end else begin
      sat_v = VW'(acc_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      pos_q    <= ns_q ? '0 : (mode_mask ? mrcs_pkg::POS_W'(elem_idx)
                                         : mrcs_pkg::POS_W'(i_q));
      val_q    <= sat_v;
      ns_out_q <= ns_q;
      last_q   <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign position_o     = pos_q;
  assign result_value_o = val_q;
  assign not_square_o   = ns_out_q;
  assign last_o         = last_q;

  // checks
  a_acc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ACC |-> $past(state_q) == ST_READ)
    else $error("ram data used without a preceding read");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide step");

  a_not_square_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && not_square_o |-> last_o)
    else $error("not-square result is not the final one");

  a_compute_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_comp && (mode_red || mode_mask) |=> state_q != ST_IDLE)
    else $error("compute transfer did not start a walk");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_load |=> state_q == ST_IDLE && out_valid_o == $past(out_valid_o || 1'b0)
      || $past(out_valid_o && !out_stall_i))
    else $error("load transfer disturbed the walk or the output");

endmodule

`default_nettype wire

// ===== tb/tb_matrix_row_column_statistics_unit.sv =====
// self-checking testbench for the matrix row/column statistics unit
`timescale 1ns / 1ps

module tb_matrix_row_column_statistics_unit;

  localparam int MAX_DIM = mrcs_pkg::MAX_DIM_DEF;
  localparam int EW = mrcs_pkg::ELEMENT_BITS_DEF;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 40;

  localparam int CFG_W   = mrcs_pkg::CFG_W;
  localparam int CIDX_W  = mrcs_pkg::CIDX_W;
  localparam int POS_W   = mrcs_pkg::POS_W;
  localparam int VALUE_W = mrcs_pkg::VALUE_W;

  // codes the block treats as no-ops
  localparam logic [CFG_W-1:0] MODE_UNUSED_LO = 4'd12;
  localparam logic [CFG_W-1:0] MODE_UNUSED_HI = 4'd15;
  localparam logic [CIDX_W-1:0] REG_SPARE = 2'd3;

  localparam int VAL_MIN = -262144;
  localparam int VAL_MAX = 262143;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    logic               ns;
    logic               last;
  } stat_result_t;

  class matrix_stats_scoreboard;
    logic signed [EW-1:0] entries[DEPTH];
    bit written[DEPTH];
    int load_ptr;
    logic [CFG_W-1:0] rows_reg, cols_reg, mode_reg;
    stat_result_t expected_stats[$];
    stat_result_t held;
    bit have_held;
    int mismatches, checked, computes;

    function new();
      load_ptr = 0;
      rows_reg = mrcs_pkg::ROW_COUNT_RST;
      cols_reg = mrcs_pkg::COL_COUNT_RST;
      mode_reg = mrcs_pkg::MODE_RST;
      foreach (written[i]) written[i] = 1'b0;
      have_held = 1'b0;
      mismatches = 0;
      checked = 0;
      computes = 0;
    endfunction

    function int dim(logic [CFG_W-1:0] d);
      if (d == 0) return 1;
      if (d > MAX_DIM) return MAX_DIM;
      return int'(d);
    endfunction

    function int rows();
      return dim(rows_reg);
    endfunction

    function int cols();
      return dim(cols_reg);
    endfunction

    function int total();
      return rows() * cols();
    endfunction

    // a compute may only read entries that hold a loaded value
    function bit can_compute();
      for (int i = 0; i < total(); i++) if (!written[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void set_register(logic [CIDX_W-1:0] idx,
                               logic [CFG_W-1:0] data);
      case (idx)
        mrcs_pkg::REG_ROW_COUNT: rows_reg = data;
        mrcs_pkg::REG_COL_COUNT: cols_reg = data;
        mrcs_pkg::REG_MODE:      mode_reg = data;
        default: ;
      endcase
    endfunction

    function int entry_at(int r, int c);
      int v;
      v = entries[r * cols() + c];
      return v;
    endfunction

    // results are held back by one so the final one can carry last
    function void add_stat(int pos, int val, bit ns);
      int s;
      s = val;
      if (s < VAL_MIN) s = VAL_MIN;
      if (s > VAL_MAX) s = VAL_MAX;
      if (have_held) expected_stats.push_back(held);
      held.pos = pos[POS_W-1:0];
      held.value = s[VALUE_W-1:0];
      held.ns = ns;
      held.last = 1'b0;
      have_held = 1'b1;
    endfunction

    function void note_item(logic act, logic signed [EW-1:0] el);
      int nr, nc, outer, inner, acc, v;
      bit by_col, keep;
      nr = rows();
      nc = cols();
      if (act == mrcs_pkg::ACT_LOAD) begin
        if (load_ptr >= nr * nc) load_ptr = 0;
        entries[load_ptr] = el;
        written[load_ptr] = 1'b1;
        load_ptr++;
        if (load_ptr >= nr * nc) load_ptr = 0;
        return;
      end
      computes++;
      have_held = 1'b0;
      if (mode_reg >= mrcs_pkg::MODE_ROW_SUM && mode_reg <= mrcs_pkg::MODE_COL_AVG) begin
        by_col = mode_reg[0];
        outer = by_col ? nc : nr;
        inner = by_col ? nr : nc;
        for (int i = 0; i < outer; i++) begin
          case (mode_reg)
            mrcs_pkg::MODE_ROW_MAX, mrcs_pkg::MODE_COL_MAX,
            mrcs_pkg::MODE_ROW_MIN, mrcs_pkg::MODE_COL_MIN:
              acc = by_col ? entry_at(0, i) : entry_at(i, 0);
            default: acc = 0;
          endcase
          for (int j = 0; j < inner; j++) begin
            v = by_col ? entry_at(j, i) : entry_at(i, j);
            case (mode_reg)
              mrcs_pkg::MODE_ROW_MAX, mrcs_pkg::MODE_COL_MAX: if (v > acc) acc = v;
              mrcs_pkg::MODE_ROW_MIN, mrcs_pkg::MODE_COL_MIN: if (v < acc) acc = v;
              default: acc = acc + v;
            endcase
          end
          // int division truncates toward zero
          if (mode_reg == mrcs_pkg::MODE_ROW_AVG || mode_reg == mrcs_pkg::MODE_COL_AVG)
            acc = acc / inner;
          add_stat(i, acc, 1'b0);
        end
      end else if (mode_reg == mrcs_pkg::MODE_DIAG || mode_reg == mrcs_pkg::MODE_ANTIDIAG ||
                   mode_reg == mrcs_pkg::MODE_UPPER || mode_reg == mrcs_pkg::MODE_LOWER) begin
        if ((mode_reg == mrcs_pkg::MODE_DIAG || mode_reg == mrcs_pkg::MODE_ANTIDIAG)
            && nr != nc) begin
          add_stat(0, 0, 1'b1);
        end else begin
          for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
              case (mode_reg)
                mrcs_pkg::MODE_DIAG:     keep = (r == c);
                mrcs_pkg::MODE_ANTIDIAG: keep = (r + c == nc - 1);
                mrcs_pkg::MODE_UPPER:    keep = (r < c);
                default:                 keep = (r > c);
              endcase
              add_stat(r * nc + c, keep ? entry_at(r, c) : 0, 1'b0);
            end
          end
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        expected_stats.push_back(held);
        have_held = 1'b0;
      end
    endfunction

    function void check_result(logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val,
                               logic ns, logic last);
      stat_result_t e;
      checked++;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pos %0d value %0d ns %b last %b",
                   pos, $signed(val), ns, last);
        return;
      end
      e = expected_stats.pop_front();
      if (pos !== e.pos || val !== e.value || ns !== e.ns || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected pos %0d value %0d ns %b last %b",
                   e.pos, $signed(e.value), e.ns, e.last);
          $display("          got      pos %0d value %0d ns %b last %b",
                   pos, $signed(val), ns, last);
        end
      end
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = mrcs_pkg::ACT_LOAD;
  logic signed [EW-1:0] element_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [POS_W-1:0] position_o;
  logic signed [VALUE_W-1:0] result_value_o;
  logic not_square_o;
  logic last_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  matrix_stats_scoreboard sb;
  int items_sent = 0;
  int settings = 0;
  int burst_left = 0;
  int hold_requests = 0;

  matrix_row_column_statistics_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .element_i      (element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .position_o     (position_o),
    .result_value_o (result_value_o),
    .not_square_o   (not_square_o),
    .last_o         (last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #(20_000_000);
    $display("Regression FAIL");
    $finish;
  end

  // receiver: shifting stall styles, plus a long hold-off on request
  int stall_style = 0;
  int style_left = 0;
  int hold_left = 0;
  int holds_done = 0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done = hold_requests;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end
      style_left = style_left - 1;
      case (stall_style)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ~out_stall_i;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(position_o, result_value_o, not_square_o, last_o);
  end

  function automatic logic [EW-1:0] rand_element();
    case ($urandom_range(0, 15))
      0, 1: return {1'b0, {(EW-1){1'b1}}};
      2, 3: return {1'b1, {(EW-1){1'b0}}};
      4:    return '0;
      5:    return '1;
      default: return EW'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0, 1, 2: return CFG_W'(MAX_DIM);
      3: return 4'd1;
      4: return 4'd0;
      5: return CFG_W'($urandom_range(MAX_DIM + 1, 15));
      default: return CFG_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [EW-1:0] el);
    in_valid_i <= 1'b1;
    action_i <= act;
    element_i <= el;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    sb.note_item(act, el);
    items_sent++;
  endtask

  // bursts of random length separated by random gaps
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // wait until all results are back, then let any result-less work drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c,
                              input logic [CFG_W-1:0] m, input bit spare);
    for (int k = 0; k < 4; k++) begin
      if (k == 3 && !spare) break;
      case (k)
        0: begin cfg_index_i <= mrcs_pkg::REG_ROW_COUNT; cfg_data_i <= r; end
        1: begin cfg_index_i <= mrcs_pkg::REG_COL_COUNT; cfg_data_i <= c; end
        2: begin cfg_index_i <= mrcs_pkg::REG_MODE; cfg_data_i <= m; end
        default: begin cfg_index_i <= REG_SPARE; cfg_data_i <= CFG_W'($urandom); end
      endcase
      cfg_valid_i <= 1'b1;
      do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
      sb.set_register(cfg_index_i, cfg_data_i);
    end
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  task automatic send_compute();
    if (sb.can_compute()) send_item(mrcs_pkg::ACT_COMPUTE, EW'($urandom));
    else send_item(mrcs_pkg::ACT_LOAD, rand_element());
  endtask

  initial begin
    int directed_items, phase;
    logic [CFG_W-1:0] nr, nc, nm;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 2x2 with the element extremes, then every mode on it
    program_regs(4'd2, 4'd2, mrcs_pkg::MODE_DIAG, 1'b0);
    send_item(mrcs_pkg::ACT_LOAD, 16'sh7fff);
    send_item(mrcs_pkg::ACT_LOAD, 16'sh8000);
    send_item(mrcs_pkg::ACT_LOAD, 16'shffff);
    send_item(mrcs_pkg::ACT_LOAD, 16'sh0000);
    for (int m = mrcs_pkg::MODE_DIAG; m <= MODE_UNUSED_LO; m++) begin
      wait_idle();
      program_regs(4'd2, 4'd2, CFG_W'(m), 1'b0);
      send_item(mrcs_pkg::ACT_COMPUTE, 16'sh0000);
    end
    wait_idle();
    program_regs(4'd2, 4'd2, MODE_UNUSED_HI, 1'b1);
    send_item(mrcs_pkg::ACT_COMPUTE, 16'shffff);

    // non-square matrix in both diagonal modes
    wait_idle();
    program_regs(4'd2, 4'd3, mrcs_pkg::MODE_DIAG, 1'b0);
    for (int k = 0; k < 6; k++) send_item(mrcs_pkg::ACT_LOAD, rand_element());
    send_item(mrcs_pkg::ACT_COMPUTE, 16'sh0000);
    wait_idle();
    program_regs(4'd2, 4'd3, mrcs_pkg::MODE_ANTIDIAG, 1'b0);
    send_item(mrcs_pkg::ACT_COMPUTE, 16'sh0000);

    // zero dimensions act as one
    wait_idle();
    program_regs(4'd0, 4'd0, mrcs_pkg::MODE_ROW_AVG, 1'b0);
    send_item(mrcs_pkg::ACT_COMPUTE, 16'sh0000);
    directed_items = items_sent;

    phase = 0;
    while (items_sent - directed_items < RANDOM_ITEMS) begin
      wait_idle();
      nr = pick_dim();
      nc = pick_dim();
      nm = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(12, 15))
                                       : CFG_W'($urandom_range(0, 11));
      if (phase == 0) begin
        nr = CFG_W'(MAX_DIM);
        nc = CFG_W'(MAX_DIM);
      end
      if (phase == 3) nm = mrcs_pkg::MODE_UPPER;
      program_regs(nr, nc, nm, $urandom_range(0, 3) == 0);

      if (!sb.can_compute() || $urandom_range(0, 1) == 1) begin
        for (int k = sb.total(); k > 0; k--) begin
          pace();
          send_item(mrcs_pkg::ACT_LOAD, rand_element());
        end
      end else if ($urandom_range(0, 3) == 0) begin
        // partial reload on top of an earlier matrix
        repeat ($urandom_range(1, 5)) begin
          pace();
          send_item(mrcs_pkg::ACT_LOAD, rand_element());
        end
      end
      repeat ($urandom_range(1, 3)) begin
        pace();
        send_compute();
      end
      repeat ($urandom_range(0, 4)) begin
        pace();
        if ($urandom_range(0, 1) == 1) send_compute();
        else send_item(mrcs_pkg::ACT_LOAD, rand_element());
      end

      if (phase == 3) begin
        // receiver holds off while computes pile up behind the output
        hold_requests <= hold_requests + 1;
        for (int k = 0; k < 6; k++) begin
          send_compute();
          send_item(mrcs_pkg::ACT_LOAD, rand_element());
        end
      end
      if (phase == 5) begin
        wait_idle();
        pace();
        send_compute();
      end
      phase++;
    end

    wait_idle();
    $display("covered %0d input items (%0d computes) across %0d register settings",
             items_sent, sb.computes, settings);
    $display("checked %0d results, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
